>>> rtl/core/bag_pkg.sv
// battery gauge package: status codes, operation codes and the fixed
// breakpoint constants of the level table
// no dependencies
package bag_pkg;

    typedef enum logic [1:0] {
        ST_ERROR    = 2'd0,
        ST_SAMPLING = 2'd1,
        ST_VALID    = 2'd2
    } t_status;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam int ADC_MAX = 4095;
    localparam int SAMPLE_W = 12;

    // breakpoints 1970..2430 in steps of 92, levels 0..100 in steps of 20
    localparam logic [11:0] BP_FIRST   = 12'd1970;
    localparam logic [11:0] BP_LAST    = 12'd2430;
    localparam logic [6:0]  BP_STEP    = 7'd92;
    localparam logic [7:0]  LEVEL_STEP = 8'd20;
    localparam logic [7:0]  LEVEL_MAX  = 8'd100;

    // floor(d * 20 / 92) for d below 92 as (d * 3565) >> 14
    localparam logic [11:0] FRAC_MUL   = 12'd3565;
    localparam int          FRAC_SHIFT = 14;

endpackage

>>> rtl/core/bag_if.sv
// valid/ready channels of the battery gauge: sample items in, status items out
// depends on bag_pkg
interface bag_in_if;
    logic              valid;
    logic              ready;
    logic              op;
    logic signed [13:0] adc_code;
    logic              charging;

    modport source (output valid, op, adc_code, charging, input ready);
    modport sink   (input valid, op, adc_code, charging, output ready);
endinterface

interface bag_out_if;
    logic               valid;
    logic               ready;
    bag_pkg::t_status   status;
    logic               is_charging;
    logic signed [12:0] last_raw;
    logic signed [12:0] average;
    logic signed [7:0]  percent;
    logic [1:0]         filled;

    modport source (output valid, status, is_charging, last_raw, average, percent, filled,
                    input ready);
    modport sink   (input valid, status, is_charging, last_raw, average, percent, filled,
                    output ready);
endinterface

>>> rtl/core/bag_div.sv
// restoring divider for the window mean, one quotient bit per cycle
// no dependencies
module bag_div #(
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [DW:0]   w_shift;
    logic          w_fits;
    logic [DW:0]   w_diff;

    assign w_shift = {r_rem, r_q[DW-1]};
    assign w_fits  = w_shift >= {1'b0, r_div};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_q   <= i_dividend;
                r_rem <= '0;
                r_div <= i_divisor;
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_rem  <= w_fits ? w_diff[DW-1:0] : w_shift[DW-1:0];
                r_q    <= {r_q[DW-2:0], w_fits};
                r_cnt  <= r_cnt - 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> rtl/core/battery_adc_average_gauge.sv
// battery gauge top level: sample window, sequencer and result register
// depends on bag_pkg, bag_if and bag_div
//
// Each item either records an ADC sample (with the charger level) or clears the
// window. A sample outside 0..4095 sets the sticky error and changes nothing
// else; a clear or a rejected sample passes straight to the done state.
// A good sample is written to a ring of WINDOW entries, the filled entries are
// summed from the window memory through a read state and an add state per
// entry, and one restoring divider of W bits (W = sum width, 14 at WINDOW = 3)
// forms the mean. The table segment is then found by repeated subtraction of
// the breakpoint step, and the interpolation step by a constant reciprocal
// multiply. When the mean is at or beyond an end breakpoint, the segment search
// and the multiply are skipped. The input is not ready while an item is at
// work; a finished result sits in the output register and the next item may be
// taken while it waits.
module battery_adc_average_gauge #(
    parameter int WINDOW = 3,
    parameter int NEEDED = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bag_in_if.sink    i_in,
    bag_out_if.source o_out
);

    localparam int PW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FW = $clog2(WINDOW + 1);
    localparam int DW = $clog2(WINDOW * bag_pkg::ADC_MAX + 1);
    localparam int SW = bag_pkg::SAMPLE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_ADD,
        S_AVG_GO,
        S_AVG_WAIT,
        S_CMP,
        S_SEG,
        S_FRAC,
        S_DONE
    } t_state;

    t_state r_state;

    // sample window
    logic [SW-1:0] r_win [WINDOW];
    logic [SW-1:0] r_rd;
    logic [PW-1:0] r_idx;

    // held values
    logic [PW-1:0]      r_wpos;
    logic [FW-1:0]      r_fill;
    logic signed [12:0] r_raw;
    logic signed [12:0] r_avg;
    logic signed [7:0]  r_level;
    logic               r_err;
    logic               r_chg;

    logic [DW-1:0] r_sum;
    logic [2:0]    r_seg;
    logic [8:0]    r_d;

    // result register
    logic               r_out_valid;
    bag_pkg::t_status   r_o_status;
    logic               r_o_chg;
    logic signed [12:0] r_o_raw;
    logic signed [12:0] r_o_avg;
    logic signed [7:0]  r_o_level;
    logic [1:0]         r_o_filled;

    logic          w_accept;
    logic          w_in_range;
    logic          w_wr;
    logic          w_load;
    logic [SW-1:0] w_avg12;
    logic          w_lvl_low;
    logic          w_lvl_high;
    logic          w_seg_fits;
    logic [18:0]   w_frac_prod;
    logic [4:0]    w_frac;
    logic          w_div_start;
    logic [DW-1:0] w_div_num;
    logic [DW-1:0] w_div_den;
    logic          w_div_done;
    logic [DW-1:0] w_div_quot;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_range = (i_in.adc_code >= 0) && (i_in.adc_code <= bag_pkg::ADC_MAX);
    assign w_wr       = w_accept && (i_in.op == bag_pkg::OP_SAMPLE) && w_in_range;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    assign w_avg12    = r_avg[SW-1:0];
    assign w_lvl_low  = w_avg12 <= bag_pkg::BP_FIRST;
    assign w_lvl_high = w_avg12 >= bag_pkg::BP_LAST;

    // segment by repeated subtraction, interpolation step by reciprocal multiply
    assign w_seg_fits  = r_d >= 9'(bag_pkg::BP_STEP);
    assign w_frac_prod = 19'(r_d) * 19'(bag_pkg::FRAC_MUL);
    assign w_frac      = 5'(w_frac_prod >> bag_pkg::FRAC_SHIFT);

    // divider forms the mean of the filled entries
    assign w_div_start = (r_state == S_AVG_GO);
    assign w_div_num   = r_sum;
    assign w_div_den   = DW'(r_fill);

    bag_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_num),
        .i_divisor  (w_div_den),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // window memory
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_win[r_wpos] <= i_in.adc_code[SW-1:0];
        end
        r_rd <= r_win[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_raw       <= -13'sd1;
            r_avg       <= -13'sd1;
            r_level     <= -8'sd1;
            r_err       <= 1'b0;
            r_chg       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_in.op == bag_pkg::OP_CLEAR) begin
                            r_fill  <= '0;
                            r_wpos  <= '0;
                            r_raw   <= -13'sd1;
                            r_avg   <= -13'sd1;
                            r_level <= -8'sd1;
                            r_err   <= 1'b0;
                            r_state <= S_DONE;
                        end else if (!w_in_range) begin
                            r_err   <= 1'b1;
                            r_state <= S_DONE;
                        end else begin
                            r_raw  <= 13'(i_in.adc_code);
                            r_chg  <= i_in.charging;
                            r_err  <= 1'b0;
                            r_wpos <= (r_wpos == PW'(WINDOW - 1)) ? '0 : r_wpos + 1'b1;
                            if (32'(r_fill) < WINDOW) begin
                                r_fill <= r_fill + 1'b1;
                            end
                            r_idx   <= '0;
                            r_sum   <= '0;
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_sum <= r_sum + DW'(r_rd);
                    if (32'(r_idx) + 1 == 32'(r_fill)) begin
                        r_state <= S_AVG_GO;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_AVG_GO: begin
                    r_state <= S_AVG_WAIT;
                end
                S_AVG_WAIT: begin
                    if (w_div_done) begin
                        r_avg   <= $signed({1'b0, w_div_quot[SW-1:0]});
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (w_lvl_low) begin
                        r_level <= '0;
                        r_state <= S_DONE;
                    end else if (w_lvl_high) begin
                        r_level <= $signed(bag_pkg::LEVEL_MAX);
                        r_state <= S_DONE;
                    end else begin
                        r_d     <= 9'(w_avg12 - bag_pkg::BP_FIRST);
                        r_seg   <= '0;
                        r_state <= S_SEG;
                    end
                end
                S_SEG: begin
                    if (w_seg_fits) begin
                        r_d   <= r_d - 9'(bag_pkg::BP_STEP);
                        r_seg <= r_seg + 1'b1;
                    end else begin
                        r_state <= S_FRAC;
                    end
                end
                S_FRAC: begin
                    r_level <= $signed(8'(r_seg) * bag_pkg::LEVEL_STEP + 8'(w_frac));
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_load) begin
                        if (r_err) begin
                            r_o_status <= bag_pkg::ST_ERROR;
                        end else if (32'(r_fill) < NEEDED) begin
                            r_o_status <= bag_pkg::ST_SAMPLING;
                        end else begin
                            r_o_status <= bag_pkg::ST_VALID;
                        end
                        r_o_chg    <= r_chg;
                        r_o_raw    <= r_raw;
                        r_o_avg    <= r_avg;
                        r_o_level  <= r_level;
                        r_o_filled <= 2'(r_fill);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_o_status;
    assign o_out.is_charging = r_o_chg;
    assign o_out.last_raw    = r_o_raw;
    assign o_out.average     = r_o_avg;
    assign o_out.percent     = r_o_level;
    assign o_out.filled      = r_o_filled;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= WINDOW && 32'(r_wpos) < WINDOW)
        else $error("window count or write position out of range");

    a_empty_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill == '0 |-> r_raw == -13'sd1 && r_avg == -13'sd1 && r_level == -8'sd1)
        else $error("empty window with held values");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE && !i_in.ready)
        else $error("item accepted without taking the sequencer");

    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_AVG_WAIT)
        else $error("divider finished outside its wait state");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !r_err && r_fill != '0 |->
            r_level >= 0 && r_level <= 8'sd100)
        else $error("level outside 0..100 with samples present");
`endif

endmodule

>>> dv/tb_battery_adc_average_gauge.sv
`timescale 1ns / 1ps
// self-checking bench for the battery gauge: directed rows, then random samples and clears
// under three idling phases; every status item is checked against a typed row or a
// local gauge model; depends on bag_pkg, bag_if and battery_adc_average_gauge
module tb_battery_adc_average_gauge;

    localparam int WINDOW     = 3;
    localparam int NEEDED     = 3;
    localparam int RAND_ITEMS = 1700;
    localparam int STALL_MAX  = 4000;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN_CYC  = 120;

    typedef enum logic [1:0] {
        PH_TX_LIGHT,
        PH_TX_HEAVY,
        PH_NO_IDLE
    } t_phase;

    typedef struct packed {
        logic               op;
        logic signed [13:0] adc;
        logic               chg;
    } t_sample_item;

    typedef struct packed {
        bag_pkg::t_status   status;
        logic               is_charging;
        logic signed [12:0] last_raw;
        logic signed [12:0] average;
        logic signed [7:0]  percent;
        logic [1:0]         filled;
    } t_gauge_status;

    typedef struct packed {
        t_sample_item  item;
        logic          typed;
        t_gauge_status want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    bag_in_if  in_ch ();
    bag_out_if out_ch ();

    battery_adc_average_gauge #(
        .WINDOW(WINDOW),
        .NEEDED(NEEDED)
    ) DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // model of the gauge state
    logic [11:0] win_mem [WINDOW];
    int          win_pos;
    int          win_fill;
    int          raw_keep;
    int          avg_keep;
    int          pct_keep;
    logic        err_sticky;
    logic        chg_keep;

    t_gauge_status pending_status[$];
    int            mismatches;
    int            tx_idle_pct;
    int            rx_idle_pct;
    t_phase        run_phase;

    function automatic int level_from_avg(int avg);
        int off;
        int seg;
        int d;
        if (avg <= int'(bag_pkg::BP_FIRST))
            return 0;
        if (avg >= int'(bag_pkg::BP_LAST))
            return int'(bag_pkg::LEVEL_MAX);
        off = avg - int'(bag_pkg::BP_FIRST);
        seg = off / int'(bag_pkg::BP_STEP);
        d   = off - seg * int'(bag_pkg::BP_STEP);
        return seg * int'(bag_pkg::LEVEL_STEP)
               + (d * int'(bag_pkg::LEVEL_STEP)) / int'(bag_pkg::BP_STEP);
    endfunction

    function automatic void gauge_clear();
        win_pos  = 0;
        win_fill = 0;
        raw_keep = -1;
        avg_keep = -1;
        pct_keep = -1;
    endfunction

    function automatic t_gauge_status gauge_predict(t_sample_item it);
        t_gauge_status r;
        int            s;
        int            sum;
        s = it.adc;
        if (it.op == bag_pkg::OP_CLEAR) begin
            gauge_clear();
            err_sticky = 1'b0;
        end else if (s < 0 || s > bag_pkg::ADC_MAX) begin
            err_sticky = 1'b1;
        end else begin
            raw_keep = s;
            chg_keep = it.chg;
            win_mem[win_pos] = s[11:0];
            win_pos = (win_pos + 1) % WINDOW;
            if (win_fill < WINDOW)
                win_fill++;
            sum = 0;
            for (int i = 0; i < win_fill; i++)
                sum += int'(win_mem[i]);
            avg_keep = sum / win_fill;
            pct_keep = level_from_avg(avg_keep);
            err_sticky = 1'b0;
        end
        if (err_sticky)
            r.status = bag_pkg::ST_ERROR;
        else if (win_fill < NEEDED)
            r.status = bag_pkg::ST_SAMPLING;
        else
            r.status = bag_pkg::ST_VALID;
        r.is_charging = chg_keep;
        r.last_raw    = 13'(raw_keep);
        r.average     = 13'(avg_keep);
        r.percent     = 8'(pct_keep);
        r.filled      = 2'(win_fill);
        return r;
    endfunction

    function automatic t_sample_item random_sample();
        t_sample_item it;
        int           pick;
        pick   = $urandom_range(99);
        it.op  = bag_pkg::OP_SAMPLE;
        it.chg = $urandom_range(1);
        if (pick < 3) begin
            it.op  = bag_pkg::OP_CLEAR;
            it.adc = 14'($urandom_range(16383));
        end else if (pick < 8) begin
            if ($urandom_range(1))
                it.adc = 14'(int'($urandom_range(4095)) - 4096);
            else
                it.adc = 14'(4096 + int'($urandom_range(4095)));
        end else if (pick < 11) begin
            it.adc = 14'($urandom_range(16383));
        end else if (pick < 56) begin
            // around the breakpoints
            it.adc = 14'($urandom_range(2500, 1900));
        end else if (pick < 66) begin
            if ($urandom_range(1))
                it.adc = 14'($urandom_range(15));
            else
                it.adc = 14'($urandom_range(4095, 4080));
        end else begin
            it.adc = 14'($urandom_range(4095));
        end
        return it;
    endfunction

    task automatic check_status(t_gauge_status want, t_gauge_status got);
        if (got.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
            mismatches++;
        end
        if (got.is_charging !== want.is_charging) begin
            $display("%0t: is_charging expected %0d got %0d", $time,
                     want.is_charging, got.is_charging);
            mismatches++;
        end
        if (got.last_raw !== want.last_raw) begin
            $display("%0t: last_raw expected %0d got %0d", $time, want.last_raw, got.last_raw);
            mismatches++;
        end
        if (got.average !== want.average) begin
            $display("%0t: average expected %0d got %0d", $time, want.average, got.average);
            mismatches++;
        end
        if (got.percent !== want.percent) begin
            $display("%0t: percent expected %0d got %0d", $time, want.percent, got.percent);
            mismatches++;
        end
        if (got.filled !== want.filled) begin
            $display("%0t: filled expected %0d got %0d", $time, want.filled, got.filled);
            mismatches++;
        end
    endtask

    task automatic sender_gap();
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // offer one item and wait for it to be taken; the model runs at the accepting edge
    task automatic offer_item(t_sample_item it, logic typed, t_gauge_status want);
        t_gauge_status predicted;
        sender_gap();
        in_ch.op       <= it.op;
        in_ch.adc_code <= it.adc;
        in_ch.charging <= it.chg;
        in_ch.valid    <= 1'b1;
        do
            @(posedge i_clk);
        while (in_ch.ready !== 1'b1);
        predicted = gauge_predict(it);
        pending_status.push_back(typed ? want : predicted);
    endtask

    // directed rows; want is don't care where typed is 0
    localparam int DIR_ROWS = 25;
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{bag_pkg::OP_CLEAR,      0, 1'b1}, 1'b1,
          '{bag_pkg::ST_SAMPLING, 1'b0,   -1,   -1,  -1, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE, -4096, 1'b1}, 1'b1,
          '{bag_pkg::ST_ERROR,    1'b0,   -1,   -1,  -1, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  8191, 1'b0}, 1'b1,
          '{bag_pkg::ST_ERROR,    1'b0,   -1,   -1,  -1, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,    -1, 1'b1}, 1'b1,
          '{bag_pkg::ST_ERROR,    1'b0,   -1,   -1,  -1, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  4096, 1'b0}, 1'b1,
          '{bag_pkg::ST_ERROR,    1'b0,   -1,   -1,  -1, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,     0, 1'b1}, 1'b1,
          '{bag_pkg::ST_SAMPLING, 1'b1,    0,    0,   0, 2'd1}},
        '{'{bag_pkg::OP_SAMPLE,  4095, 1'b0}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  4095, 1'b1}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  4095, 1'b1}, 1'b1,
          '{bag_pkg::ST_VALID,    1'b1, 4095, 4095, 100, 2'd3}},
        '{'{bag_pkg::OP_SAMPLE, -4096, 1'b0}, 1'b1,
          '{bag_pkg::ST_ERROR,    1'b1, 4095, 4095, 100, 2'd3}},
        '{'{bag_pkg::OP_CLEAR,   8191, 1'b0}, 1'b1,
          '{bag_pkg::ST_SAMPLING, 1'b1,   -1,   -1,  -1, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  1970, 1'b0}, 1'b1,
          '{bag_pkg::ST_SAMPLING, 1'b0, 1970, 1970,   0, 2'd1}},
        '{'{bag_pkg::OP_SAMPLE,  1969, 1'b1}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  2430, 1'b0}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  2430, 1'b1}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  2430, 1'b0}, 1'b1,
          '{bag_pkg::ST_VALID,    1'b0, 2430, 2430, 100, 2'd3}},
        '{'{bag_pkg::OP_SAMPLE,  2429, 1'b1}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  2062, 1'b0}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  2154, 1'b1}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_CLEAR,     -1, 1'b0}, 1'b1,
          '{bag_pkg::ST_SAMPLING, 1'b1,   -1,   -1,  -1, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  2431, 1'b0}, 1'b1,
          '{bag_pkg::ST_SAMPLING, 1'b0, 2431, 2431, 100, 2'd1}},
        '{'{bag_pkg::OP_SAMPLE,  2246, 1'b1}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  2338, 1'b0}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  5000, 1'b1}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}},
        '{'{bag_pkg::OP_SAMPLE,  2000, 1'b0}, 1'b0,
          '{bag_pkg::ST_ERROR,    1'b0,    0,    0,   0, 2'd0}}
    };

    // status sink: checks each item taken, then picks ready for the next edge
    initial begin
        int            hold_left;
        logic          hold_done;
        t_gauge_status got;
        hold_left    = 0;
        hold_done    = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.status      = out_ch.status;
                got.is_charging = out_ch.is_charging;
                got.last_raw    = out_ch.last_raw;
                got.average     = out_ch.average;
                got.percent     = out_ch.percent;
                got.filled      = out_ch.filled;
                if (pending_status.size() == 0) begin
                    $display("%0t: status item with none expected", $time);
                    mismatches++;
                end else begin
                    check_status(pending_status.pop_front(), got);
                end
            end
            if (i_rst_n !== 1'b1) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (run_phase == PH_NO_IDLE && !hold_done) begin
                // long hold-off while the sender keeps offering
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog on cycles with no item taken on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_MAX) begin
            @(posedge i_clk);
            if ((in_ch.valid & in_ch.ready) === 1'b1 || (out_ch.valid & out_ch.ready) === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_battery_adc_average_gauge: errors");
        $finish;
    end

    initial begin
        t_gauge_status none;
        mismatches     = 0;
        none           = '0;
        run_phase      = PH_TX_LIGHT;
        tx_idle_pct    = 28;
        rx_idle_pct    = 83;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.op       = bag_pkg::OP_SAMPLE;
        in_ch.adc_code = '0;
        in_ch.charging = 1'b0;
        err_sticky     = 1'b0;
        chg_keep       = 1'b0;
        for (int i = 0; i < WINDOW; i++)
            win_mem[i] = '0;
        gauge_clear();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i])
            offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS / 3) begin
                run_phase   = PH_TX_HEAVY;
                tx_idle_pct = 83;
                rx_idle_pct = 28;
            end else if (n == 2 * RAND_ITEMS / 3) begin
                run_phase   = PH_NO_IDLE;
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            offer_item(random_sample(), 1'b0, none);
        end
        in_ch.valid <= 1'b0;

        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("tb_battery_adc_average_gauge: clean");
        else
            $display("tb_battery_adc_average_gauge: errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/bag_pkg.sv
rtl/core/bag_if.sv
rtl/core/bag_div.sv
rtl/core/battery_adc_average_gauge.sv
dv/tb_battery_adc_average_gauge.sv
